### hw/rtl/ters_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ters_pkg
// Shared types and constants of the thermal erosion stencil.
// ----------------------------------------------------------------------------
package ters_pkg;

  // Fixed field widths
  localparam int SED_W      = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Saturation bounds of the sediment field
  localparam int SED_MAX = 8388607;
  localparam int SED_MIN = -8388608;

  // Neighbor weights: axial terms are a shift, diagonals multiply by 0.707 in Q0.10
  localparam int AXIAL_SHIFT = 10;
  localparam int DIAG_WEIGHT = 724;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RASTER_WIDTH  = 3'd0,
    REG_RASTER_HEIGHT = 3'd1,
    REG_HEIGHT_SCALE  = 3'd2,
    REG_THRESH_X      = 3'd3,
    REG_THRESH_Z      = 3'd4,
    REG_THRESH_DIAG   = 3'd5,
    REG_RATE          = 3'd6
  } ters_reg_t;

  // Window taps in read order: center first, then the eight neighbors
  localparam logic [3:0] TAP_CENTER = 4'd0;
  localparam logic [3:0] TAP_LEFT   = 4'd1;
  localparam logic [3:0] TAP_RIGHT  = 4'd2;
  localparam logic [3:0] TAP_TOP    = 4'd3;
  localparam logic [3:0] TAP_BOT    = 4'd4;
  localparam logic [3:0] TAP_TOP_LF = 4'd5;
  localparam logic [3:0] TAP_TOP_RT = 4'd6;
  localparam logic [3:0] TAP_BOT_LF = 4'd7;
  localparam logic [3:0] TAP_BOT_RT = 4'd8;

  // Result jobs an item can cause, in emission order
  localparam logic [1:0] JOB_PREV_LEFT = 2'd0;
  localparam logic [1:0] JOB_PREV_HERE = 2'd1;
  localparam logic [1:0] JOB_LAST_LEFT = 2'd2;
  localparam logic [1:0] JOB_LAST_HERE = 2'd3;

  // Arithmetic settings
  typedef struct packed {
    logic [15:0] height_scale;
    logic [15:0] thresh_x;
    logic [15:0] thresh_z;
    logic [15:0] thresh_diag;
    logic [15:0] rate;
  } ters_cfg_t;

  // Tap tag that travels alongside the memory read data
  typedef struct packed {
    logic       valid;
    logic [3:0] tap;
  } ters_tap_t;

endpackage

### hw/rtl/ters_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ters_mem
// Height line store (three rows) and sediment delay store (two rows).
// ----------------------------------------------------------------------------
module ters_mem #(
  parameter int MAX_WIDTH   = 1024,
  parameter int HEIGHT_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  h_we,
  input  logic [$clog2(3*MAX_WIDTH)-1:0]        h_waddr,
  input  logic [HEIGHT_BITS-1:0]                h_wdata,
  input  logic [$clog2(3*MAX_WIDTH)-1:0]        h_raddr,
  output logic [HEIGHT_BITS-1:0]                h_rdata,
  input  logic                                  s_we,
  input  logic [$clog2(2*MAX_WIDTH)-1:0]        s_waddr,
  input  logic signed [ters_pkg::SED_W-1:0]     s_wdata,
  input  logic [$clog2(2*MAX_WIDTH)-1:0]        s_raddr,
  output logic signed [ters_pkg::SED_W-1:0]     s_rdata
);

  localparam int H_DEPTH = 3 * MAX_WIDTH;
  localparam int S_DEPTH = 2 * MAX_WIDTH;

  logic [HEIGHT_BITS-1:0]            height_rows [H_DEPTH];
  logic signed [ters_pkg::SED_W-1:0] sediment_delay [S_DEPTH];

  // Height rows: one write, one registered read
  always_ff @(posedge clk) begin
    if (h_we) begin
      height_rows[h_waddr] <= h_wdata;
    end
    h_rdata <= height_rows[h_raddr];
  end

  // Sediment rows
  always_ff @(posedge clk) begin
    if (s_we) begin
      sediment_delay[s_waddr] <= s_wdata;
    end
    s_rdata <= sediment_delay[s_raddr];
  end

endmodule

### hw/rtl/ters_calc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ters_calc
// Erosion datapath: takes the center and eight neighbor heights one per
// cycle, accumulates thresholded slopes, then scales, clamps and saturates.
// ----------------------------------------------------------------------------
module ters_calc #(
  parameter int HEIGHT_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  ters_pkg::ters_cfg_t               cfg,
  input  ters_pkg::ters_tap_t               tap,
  input  logic [HEIGHT_BITS-1:0]            hdata,
  input  logic signed [ters_pkg::SED_W-1:0] sdata,
  output logic                              res_valid,
  output logic [HEIGHT_BITS-1:0]            new_height,
  output logic signed [ters_pkg::SED_W-1:0] new_sediment,
  output logic                              overflow,
  output logic                              changed
);

  localparam int HB   = HEIGHT_BITS;
  localparam int SW_  = ters_pkg::SED_W;
  localparam int DW   = HB + 18;          // scaled difference
  localparam int ACW  = HB + 20;          // sum of four differences
  localparam int SW   = HB + 31;          // weighted sum
  localparam int M8W  = SW - 9;           // magnitude in Q.8
  localparam int PW   = M8W + 16;         // magnitude times rate
  localparam int LW   = HB + 23;          // clamp limit
  localparam int EW   = HB + 26;          // sediment working width

  localparam logic signed [11:0]   DIAG_W  = 12'(ters_pkg::DIAG_WEIGHT);
  localparam logic signed [EW-1:0] SED_HI  = EW'(ters_pkg::SED_MAX);
  localparam logic signed [EW-1:0] SED_LO  = EW'(ters_pkg::SED_MIN);

  // Stage 1: capture center, form scaled difference
  logic [HB-1:0]          orig;
  logic signed [SW_-1:0]  sed;
  logic signed [HB:0]     diff;
  logic signed [16:0]     scale_s;
  logic signed [DW-1:0]   dh_next;
  logic signed [DW-1:0]   dh;
  logic                   s1_valid;
  logic [3:0]             s1_tap;

  assign diff    = $signed({1'b0, orig}) - $signed({1'b0, hdata});
  assign scale_s = $signed({1'b0, cfg.height_scale});
  assign dh_next = scale_s * diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= tap.valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_tap <= tap.tap;
    if (tap.valid) begin
      if (tap.tap == ters_pkg::TAP_CENTER) begin
        orig <= hdata;
        sed  <= sdata;
      end else begin
        dh <= dh_next;
      end
    end
  end

  // Stage 2: threshold test and accumulate axial / diagonal sums
  logic [15:0]            thr;
  logic                   axial;
  logic [DW-1:0]          adh;
  logic signed [ACW-1:0]  acc_a;
  logic signed [ACW-1:0]  acc_d;

  always_comb begin
    case (s1_tap)
      ters_pkg::TAP_LEFT, ters_pkg::TAP_RIGHT: begin
        thr   = cfg.thresh_x;
        axial = 1'b1;
      end
      ters_pkg::TAP_TOP, ters_pkg::TAP_BOT: begin
        thr   = cfg.thresh_z;
        axial = 1'b1;
      end
      default: begin
        thr   = cfg.thresh_diag;
        axial = 1'b0;
      end
    endcase
  end

  assign adh = dh[DW-1] ? DW'(-dh) : DW'(dh);

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      if (s1_tap == ters_pkg::TAP_CENTER) begin
        acc_a <= '0;
        acc_d <= '0;
      end else if (adh > DW'({thr, 8'h00})) begin
        if (axial) begin
          acc_a <= acc_a + ACW'(dh);
        end else begin
          acc_d <= acc_d + ACW'(dh);
        end
      end
    end
  end

  // Final stages, tracked by a valid shift line
  logic [4:0] fin;
  always_ff @(posedge clk) begin
    if (rst) begin
      fin <= '0;
    end else begin
      fin <= {fin[3:0], s1_valid && (s1_tap == ters_pkg::TAP_BOT_RT)};
    end
  end

  // F1: diagonal weighting
  logic signed [SW-1:0]  dwt_next;
  logic signed [SW-1:0]  dwt;
  logic signed [ACW-1:0] acc_a_q;
  assign dwt_next = acc_d * DIAG_W;

  always_ff @(posedge clk) begin
    if (fin[0]) begin
      dwt     <= dwt_next;
      acc_a_q <= acc_a;
    end
  end

  // F2: total, magnitude rounded to Q.8
  logic signed [SW-1:0] sum;
  logic [SW-1:0]        mag;
  logic [SW:0]          magr;
  logic [M8W-1:0]       mag8;
  logic                 neg;

  assign sum  = (SW'(acc_a_q) <<< ters_pkg::AXIAL_SHIFT) + dwt;
  assign mag  = sum[SW-1] ? SW'(-sum) : SW'(sum);
  assign magr = {1'b0, mag} + (SW+1)'(512);

  always_ff @(posedge clk) begin
    if (fin[1]) begin
      neg  <= sum[SW-1];
      mag8 <= magr[SW:10];
    end
  end

  // F3: movement times rate
  logic [PW-1:0] prod_next;
  logic [PW-1:0] prod;
  assign prod_next = PW'(mag8) * PW'(cfg.rate);

  always_ff @(posedge clk) begin
    if (fin[2]) begin
      prod <= prod_next;
    end
  end

  // F4: clamp to half height, round, apply and saturate
  logic [LW-1:0]          limit;
  logic [LW-1:0]          p;
  logic [LW:0]            psum;
  logic [HB-1:0]          m;
  logic [HB:0]            hsum;
  logic [HB-1:0]          hnew;
  logic                   hovf;
  logic signed [EW-1:0]   sed_x;
  logic signed [EW-1:0]   m_x;
  logic signed [EW-1:0]   swide;
  logic signed [SW_-1:0]  snew;
  logic                   sovf;

  always_comb begin
    limit = {orig, 23'd0};
    p     = (prod > PW'(limit)) ? limit : LW'(prod);
    psum  = {1'b0, p} + (LW+1)'(24'h800000);
    m     = psum[LW:24];
    if (neg) begin
      hsum = {1'b0, orig} + {1'b0, m};
    end else begin
      hsum = {1'b0, orig} - {1'b0, m};
    end
    hovf  = hsum[HB];
    hnew  = hovf ? '1 : hsum[HB-1:0];
    sed_x = EW'(sed);
    m_x   = $signed(EW'(m));
    swide = neg ? (sed_x - m_x) : (sed_x + m_x);
    sovf  = 1'b0;
    if (swide > SED_HI) begin
      snew = SW_'(SED_HI);
      sovf = 1'b1;
    end else if (swide < SED_LO) begin
      snew = SW_'(SED_LO);
      sovf = 1'b1;
    end else begin
      snew = SW_'(swide);
    end
  end

  always_ff @(posedge clk) begin
    if (fin[3]) begin
      new_height   <= hnew;
      new_sediment <= snew;
      overflow     <= hovf || sovf;
      changed      <= (hnew != orig) || (snew != sed);
    end
  end

  assign res_valid = fin[4];

endmodule

### hw/rtl/thermal_erosion_stencil.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thermal_erosion_stencil
// Streamed 3x3 thermal erosion over a heightmap in raster order.
//
//   channel  dir  handshake          payload
//   s_*      in   s_tvalid/s_tready  s_tdata: cell_height, cell_sediment
//   m_*      out  m_tvalid/m_tready  m_tdata, m_tlast (last), m_tuser (frame_end)
//   cfg_*    in   cfg_we             cfg_addr, cfg_data
//
// One item is taken at a time. An item is written to the line stores in the
// cycle it is accepted; the sequencer then works through its zero to four
// results, each reading the nine window heights through the single read
// port of the height store and then passing through the datapath.
// An item without results frees the input once the sequencer finds no job;
// each result adds its reads, the datapath and any wait for the output register.
// rst is synchronous; a result waits in the output register while m_tready
// is low, and the next item can be taken while it waits.
// ----------------------------------------------------------------------------
module thermal_erosion_stencil #(
  parameter int MAX_WIDTH   = 1024,
  parameter int HEIGHT_BITS = 16
) (
  input  logic                                          clk,
  input  logic                                          rst,
  // cell_height [HEIGHT_BITS-1:0], cell_sediment [HEIGHT_BITS+23:HEIGHT_BITS]
  input  logic [((HEIGHT_BITS+24+7)/8)*8-1:0]           s_tdata,
  input  logic                                          s_tvalid,
  output logic                                          s_tready,
  // new_height, new_sediment, overflow, changed
  output logic [((HEIGHT_BITS+26+7)/8)*8-1:0]           m_tdata,
  output logic                                          m_tuser,   // frame_end
  output logic                                          m_tlast,   // last
  output logic                                          m_tvalid,
  input  logic                                          m_tready,
  input  logic                                          cfg_we,
  input  logic [ters_pkg::CFG_IDX_W-1:0]                cfg_addr,
  input  logic [ters_pkg::CFG_DATA_W-1:0]               cfg_data
);

  localparam int HB   = HEIGHT_BITS;
  localparam int SW_  = ters_pkg::SED_W;
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int HAW  = $clog2(3 * MAX_WIDTH);
  localparam int SAW  = $clog2(2 * MAX_WIDTH);
  localparam int MDW  = ((HB + 26 + 7) / 8) * 8;

  // Configuration registers
  logic [10:0]          raster_width;
  logic [15:0]          raster_height;
  ters_pkg::ters_cfg_t  cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      raster_width     <= 11'd1024;
      raster_height    <= 16'd1024;
      cfg.height_scale <= 16'd256;
      cfg.thresh_x     <= '0;
      cfg.thresh_z     <= '0;
      cfg.thresh_diag  <= '0;
      cfg.rate         <= '0;
    end else if (cfg_we) begin
      case (ters_pkg::ters_reg_t'(cfg_addr))
        ters_pkg::REG_RASTER_WIDTH:  raster_width     <= cfg_data[10:0];
        ters_pkg::REG_RASTER_HEIGHT: raster_height    <= cfg_data;
        ters_pkg::REG_HEIGHT_SCALE:  cfg.height_scale <= cfg_data;
        ters_pkg::REG_THRESH_X:      cfg.thresh_x     <= cfg_data;
        ters_pkg::REG_THRESH_Z:      cfg.thresh_z     <= cfg_data;
        ters_pkg::REG_THRESH_DIAG:   cfg.thresh_diag  <= cfg_data;
        ters_pkg::REG_RATE:          cfg.rate         <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective geometry
  logic [WW-1:0] w_eff;
  logic [16:0]   h_eff;
  always_comb begin
    if (32'(raster_width) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else if (raster_width == '0) begin
      w_eff = WW'(1);
    end else begin
      w_eff = WW'(raster_width);
    end
    h_eff = (raster_height == '0) ? 17'h10000 : {1'b0, raster_height};
  end

  // Sequencer states
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_PICK = 5'b00010,
    ST_READ = 5'b00100,
    ST_CALC = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

  state_t state, state_next;

  // Raster position
  logic [CW-1:0] col;
  logic [15:0]   row;
  logic [1:0]    row3;
  logic          endcol;
  logic          lastrow;
  logic          accept;

  assign s_tready = (state == ST_IDLE) && !rst;
  assign accept   = s_tvalid && s_tready;
  assign endcol   = (32'(col) + 1) >= 32'(w_eff);
  assign lastrow  = ({1'b0, row} + 17'd1) >= h_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      col  <= '0;
      row  <= '0;
      row3 <= '0;
    end else if (accept) begin
      if (endcol) begin
        col <= '0;
        if (lastrow) begin
          row  <= '0;
          row3 <= '0;
        end else begin
          row  <= row + 16'd1;
          row3 <= (row3 == 2'd2) ? 2'd0 : row3 + 2'd1;
        end
      end else begin
        col <= col + CW'(1);
      end
    end
  end

  // Jobs of the current item
  logic [3:0]    jobs;
  logic [CW-1:0] jc;
  logic [WW-1:0] jw;
  logic          jr0, jr1, jpar;
  logic [1:0]    jr3;

  // Selected job
  logic [1:0] cur_j;
  logic       job_even;
  logic       job_prev;
  logic [1:0] pm1, pp1;
  logic [1:0] ys_sel, bs_sel;
  logic [CW-1:0] x_sel;

  always_comb begin
    if (jobs[0]) begin
      cur_j = ters_pkg::JOB_PREV_LEFT;
    end else if (jobs[1]) begin
      cur_j = ters_pkg::JOB_PREV_HERE;
    end else if (jobs[2]) begin
      cur_j = ters_pkg::JOB_LAST_LEFT;
    end else begin
      cur_j = ters_pkg::JOB_LAST_HERE;
    end
    job_even = (cur_j == ters_pkg::JOB_PREV_LEFT) || (cur_j == ters_pkg::JOB_LAST_LEFT);
    job_prev = (cur_j == ters_pkg::JOB_PREV_LEFT) || (cur_j == ters_pkg::JOB_PREV_HERE);
    pm1 = (jr3 == 2'd0) ? 2'd2 : jr3 - 2'd1;
    pp1 = (jr3 == 2'd2) ? 2'd0 : jr3 + 2'd1;
    if (job_prev) begin
      ys_sel = pm1;
      bs_sel = jr1 ? pm1 : pp1;
    end else begin
      ys_sel = jr3;
      bs_sel = jr0 ? jr3 : pm1;
    end
    x_sel = job_even ? jc - CW'(1) : jc;
  end

  // Latched window description
  logic [1:0]    ys, ts, bs;
  logic [CW-1:0] xc, xl, xr;
  logic          spar, j_fe, j_last;
  logic [1:0]    j_id;
  logic [3:0]    k;

  always_ff @(posedge clk) begin
    if (accept) begin
      jc   <= col;
      jw   <= w_eff;
      jr0  <= (row == 16'd0);
      jr1  <= (row == 16'd1);
      jpar <= row[0];
      jr3  <= row3;
    end
    if (state == ST_PICK) begin
      ys     <= ys_sel;
      ts     <= jr3;
      bs     <= bs_sel;
      xc     <= x_sel;
      xl     <= (x_sel == '0) ? x_sel : x_sel - CW'(1);
      xr     <= ((32'(x_sel) + 1) < 32'(jw)) ? x_sel + CW'(1) : x_sel;
      spar   <= job_prev ? !jpar : jpar;
      j_id   <= cur_j;
      j_fe   <= (cur_j == ters_pkg::JOB_LAST_HERE);
      j_last <= ((jobs >> cur_j) >> 1) == 4'd0;
    end
  end

  // Job mask
  always_ff @(posedge clk) begin
    if (rst) begin
      jobs <= '0;
    end else if (accept) begin
      jobs <= {lastrow && endcol, lastrow && (col != '0),
               (row != '0) && endcol, (row != '0) && (col != '0)};
    end else if ((state == ST_EMIT) && (!m_tvalid || m_tready)) begin
      jobs <= jobs & ~(4'd1 << j_id);
    end
  end

  // Tap address selection
  logic [1:0]    rd_slot;
  logic [CW-1:0] rd_col;
  always_comb begin
    case (k)
      ters_pkg::TAP_CENTER: begin rd_slot = ys; rd_col = xc; end
      ters_pkg::TAP_LEFT:   begin rd_slot = ys; rd_col = xl; end
      ters_pkg::TAP_RIGHT:  begin rd_slot = ys; rd_col = xr; end
      ters_pkg::TAP_TOP:    begin rd_slot = ts; rd_col = xc; end
      ters_pkg::TAP_BOT:    begin rd_slot = bs; rd_col = xc; end
      ters_pkg::TAP_TOP_LF: begin rd_slot = ts; rd_col = xl; end
      ters_pkg::TAP_TOP_RT: begin rd_slot = ts; rd_col = xr; end
      ters_pkg::TAP_BOT_LF: begin rd_slot = bs; rd_col = xl; end
      default:              begin rd_slot = bs; rd_col = xr; end
    endcase
  end

  // Row slot to store address
  function automatic logic [HAW-1:0] h_addr(input logic [1:0] slot, input logic [CW-1:0] c);
    logic [HAW-1:0] base;
    case (slot)
      2'd0:    base = '0;
      2'd1:    base = HAW'(MAX_WIDTH);
      default: base = HAW'(2 * MAX_WIDTH);
    endcase
    return base + HAW'(c);
  endfunction

  function automatic logic [SAW-1:0] s_addr(input logic par, input logic [CW-1:0] c);
    return (par ? SAW'(MAX_WIDTH) : SAW'(0)) + SAW'(c);
  endfunction

  // Line stores
  logic [HB-1:0]          h_rdata;
  logic signed [SW_-1:0]  s_rdata;

  ters_mem #(
    .MAX_WIDTH   (MAX_WIDTH),
    .HEIGHT_BITS (HB)
  ) u_mem (
    .clk     (clk),
    .h_we    (accept),
    .h_waddr (h_addr(row3, col)),
    .h_wdata (s_tdata[HB-1:0]),
    .h_raddr (h_addr(rd_slot, rd_col)),
    .h_rdata (h_rdata),
    .s_we    (accept),
    .s_waddr (s_addr(row[0], col)),
    .s_wdata ($signed(s_tdata[HB+SW_-1:HB])),
    .s_raddr (s_addr(spar, xc)),
    .s_rdata (s_rdata)
  );

  // Tap tag lines up with the read data
  ters_pkg::ters_tap_t tap_q;
  always_ff @(posedge clk) begin
    if (rst) begin
      tap_q.valid <= 1'b0;
    end else begin
      tap_q.valid <= (state == ST_READ);
    end
    tap_q.tap <= k;
  end

  // Datapath
  logic                  res_valid;
  logic [HB-1:0]         r_height;
  logic signed [SW_-1:0] r_sed;
  logic                  r_ovf, r_chg;

  ters_calc #(
    .HEIGHT_BITS (HB)
  ) u_calc (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .tap          (tap_q),
    .hdata        (h_rdata),
    .sdata        (s_rdata),
    .res_valid    (res_valid),
    .new_height   (r_height),
    .new_sediment (r_sed),
    .overflow     (r_ovf),
    .changed      (r_chg)
  );

  // State machine
  logic emit_go;
  assign emit_go = (state == ST_EMIT) && (!m_tvalid || m_tready);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept) state_next = ST_PICK;
      ST_PICK: state_next = (jobs == '0) ? ST_IDLE : ST_READ;
      ST_READ: if (k == ters_pkg::TAP_BOT_RT) state_next = ST_CALC;
      ST_CALC: if (res_valid) state_next = ST_EMIT;
      ST_EMIT: if (emit_go) state_next = ST_PICK;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      k     <= '0;
    end else begin
      state <= state_next;
      if (state == ST_READ) begin
        k <= k + 4'd1;
      end else begin
        k <= ters_pkg::TAP_CENTER;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit_go) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      m_tdata <= MDW'({r_chg, r_ovf, r_sed, r_height});
      m_tuser <= j_fe;
      m_tlast <= j_last;
    end
  end

endmodule

### hw/rtl/ters_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ters_chk
// Port-level checks of the thermal erosion stencil.
// ----------------------------------------------------------------------------
module ters_chk #(
  parameter int HEIGHT_BITS = 16
) (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  s_tvalid,
  input logic                                  s_tready,
  input logic [((HEIGHT_BITS+26+7)/8)*8-1:0]   m_tdata,
  input logic                                  m_tuser,
  input logic                                  m_tlast,
  input logic                                  m_tvalid,
  input logic                                  m_tready
);

  // One item in flight: input closes right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while an item is in flight");

  // A new result is loaded only while the input is closed
  a_load_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !s_tready)
    else $error("result appeared while input open");

  // Frame end is always the last result of its item
  a_fe_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("frame end not marked last");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
      && $stable(m_tuser))
    else $error("stalled result changed");

  // Reset empties the output
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind thermal_erosion_stencil ters_chk #(.HEIGHT_BITS(HEIGHT_BITS)) u_ters_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready)
);
